// ===== rtl/core/tfs_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tfs_pkg
// Shared types, constants and the bytewise CRC-16 step of the telemetry
// frame sender.
// ---------------------------------------------------------------------------
package tfs_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned IDX_W        = 4;
    localparam int unsigned IN_SLOT_W    = 3;
    localparam int unsigned ACT_W        = 4;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned POS_W        = 5;
    localparam int unsigned CNT_W        = 5;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 2'd1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    localparam logic [BYTE_W-1:0] HEADER_RST  = 8'd165;
    localparam logic [ACT_W-1:0]  ACTIVE_RST  = 4'd0;
    localparam logic [BYTE_W-1:0] FRAME_B1    = 8'h80;
    localparam logic [BYTE_W-1:0] FRAME_B2    = 8'h15;
    localparam logic [15:0]       CRC_POLY    = 16'h1021;
    localparam logic [15:0]       CRC_TOP     = 16'h8000;

    // byte positions inside the outgoing frame
    localparam logic [POS_W-1:0] POS_HDR       = 5'd0;
    localparam logic [POS_W-1:0] POS_B1        = 5'd1;
    localparam logic [POS_W-1:0] POS_B2        = 5'd2;
    localparam logic [POS_W-1:0] POS_PAY_FIRST = 5'd3;
    localparam logic [POS_W-1:0] POS_CRC_HI    = 5'd19;
    localparam logic [POS_W-1:0] POS_CRC_LO    = 5'd20;

    typedef struct packed {
        logic                 is_send;
        logic [IN_SLOT_W-1:0] slot;
        logic [IDX_W-1:0]     idx;
        logic [BYTE_W-1:0]    data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                             input logic [BYTE_W-1:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tfs_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tfs_front
// Accepts input beats, matches received headers against the configured
// header under a mute flag and queues payload writes and frame sends in arrival order.
// ---------------------------------------------------------------------------
module tfs_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_op,
    input  wire logic [tfs_pkg::IN_SLOT_W-1:0]   i_slot,
    input  wire logic [tfs_pkg::IDX_W-1:0]       i_byte_index,
    input  wire logic [tfs_pkg::BYTE_W-1:0]      i_data,
    input  wire logic [tfs_pkg::BYTE_W-1:0]      i_header,
    input  wire tfs_pkg::t_qstat                 i_qstat,
    output logic                                 o_push,
    output tfs_pkg::t_cmd                        o_cmd
);

    logic r_mute;
    logic n_mute;
    logic accept;
    logic match;

    assign o_in_stall = i_qstat.full;
    assign accept     = i_in_valid && !i_qstat.full;
    assign match      = (i_op == tfs_pkg::OP_FRAME) && (i_data == i_header);

    always_comb begin
        n_mute = r_mute;
        if (accept && match) begin
            n_mute = !r_mute;
        end
    end

    // a match while unmuted is the second of a pair and sends a frame
    assign o_push = accept && ((i_op == tfs_pkg::OP_WRITE) || (match && !r_mute));

    always_comb begin
        o_cmd.is_send = (i_op == tfs_pkg::OP_FRAME);
        o_cmd.slot    = i_slot;
        o_cmd.idx     = i_byte_index;
        o_cmd.data    = i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mute <= 1'b1;
        end else begin
            r_mute <= n_mute;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/tfs_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tfs_queue
// Two-entry command queue between the front and the frame engine.
// ---------------------------------------------------------------------------
module tfs_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tfs_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output tfs_pkg::t_cmd      o_head,
    output tfs_pkg::t_qstat    o_qstat
);

    tfs_pkg::t_cmd r_ent [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          do_push;
    logic          do_pop;

    assign o_qstat.full  = (r_count == 2'd2);
    assign o_qstat.empty = (r_count == 2'd0);
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_head        = r_ent[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/tfs_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tfs_back
// Payload store and frame engine: applies payload writes and streams a
// 21-byte frame per send, one byte per cycle unless stalled, with a running CRC-16.
// ---------------------------------------------------------------------------
module tfs_back #(
    parameter int unsigned SLOT_COUNT = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tfs_pkg::t_cmd                 i_head,
    input  wire tfs_pkg::t_qstat               i_qstat,
    output logic                               o_pop,
    input  wire logic [tfs_pkg::BYTE_W-1:0]    i_header,
    input  wire logic [tfs_pkg::ACT_W-1:0]     i_active,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [tfs_pkg::BYTE_W-1:0]         o_tx_byte,
    output logic                               o_last
);

    localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned AW     = SLOT_W + tfs_pkg::IDX_W;
    localparam int unsigned DEPTH  = SLOT_COUNT * 16;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEND = 1'b1;

    logic [tfs_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_written;

    logic                          r_state;
    logic [SLOT_W-1:0]             r_ptr;
    logic [SLOT_W-1:0]             r_cur;
    logic [tfs_pkg::CNT_W-1:0]     r_cnt;
    logic [tfs_pkg::POS_W-1:0]     r_pos;
    logic [15:0]                   r_crc;
    logic [tfs_pkg::BYTE_W-1:0]    r_rd_data;
    logic                          r_rd_vld;
    logic                          r_out_valid;
    logic [tfs_pkg::BYTE_W-1:0]    r_out_byte;
    logic                          r_out_last;

    logic [tfs_pkg::POS_W-1:0]     n_pos;
    logic [tfs_pkg::CNT_W-1:0]     act_ext;
    logic [tfs_pkg::CNT_W-1:0]     slots_ext;
    logic [tfs_pkg::CNT_W-1:0]     cnt_eff;
    logic [tfs_pkg::CNT_W-1:0]     ptr_ext;
    logic [tfs_pkg::CNT_W-1:0]     cur_ext;
    logic [tfs_pkg::CNT_W-1:0]     cur_inc;
    logic [tfs_pkg::CNT_W-1:0]     slot_ext;
    logic [tfs_pkg::POS_W-1:0]     pay_off;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 wr_addr;
    logic                          take;
    logic                          wr_en;
    logic                          out_free;
    logic                          advance;
    logic [tfs_pkg::BYTE_W-1:0]    cur_byte;

    assign take    = (r_state == ST_IDLE) && !i_qstat.empty;
    assign o_pop   = take;

    assign slot_ext = tfs_pkg::CNT_W'(i_head.slot);
    assign wr_addr  = {slot_ext[SLOT_W-1:0], i_head.idx};
    assign wr_en    = take && !i_head.is_send && (slot_ext < slots_ext);

    // active count clamped to the slots present
    assign act_ext   = tfs_pkg::CNT_W'(i_active);
    assign slots_ext = tfs_pkg::CNT_W'(SLOT_COUNT);
    assign cnt_eff   = (act_ext > slots_ext) ? slots_ext : act_ext;
    assign ptr_ext   = tfs_pkg::CNT_W'(r_ptr);
    assign cur_ext   = (ptr_ext >= cnt_eff) ? '0 : ptr_ext;
    assign cur_inc   = tfs_pkg::CNT_W'(r_cur) + 1'b1;

    assign out_free = !r_out_valid || !i_out_stall;
    assign advance  = (r_state == ST_SEND) && out_free;
    assign n_pos    = advance ? (r_pos + 1'b1) : r_pos;

    // prefetch the payload byte for the position loaded next
    assign pay_off  = n_pos - tfs_pkg::POS_PAY_FIRST;
    assign rd_addr  = {r_cur, pay_off[tfs_pkg::IDX_W-1:0]};

    always_comb begin
        case (r_pos)
            tfs_pkg::POS_HDR:     cur_byte = i_header;
            tfs_pkg::POS_B1:      cur_byte = tfs_pkg::FRAME_B1;
            tfs_pkg::POS_B2:      cur_byte = tfs_pkg::FRAME_B2;
            tfs_pkg::POS_CRC_HI:  cur_byte = r_crc[15:8];
            tfs_pkg::POS_CRC_LO:  cur_byte = r_crc[7:0];
            default:              cur_byte = r_rd_vld ? r_rd_data : '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_head.data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_written[wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_written[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ptr       <= '0;
            r_cur       <= '0;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
            r_out_byte  <= '0;
            r_out_last  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (take && i_head.is_send && (cnt_eff != '0)) begin
                        r_state <= ST_SEND;
                        r_cur   <= cur_ext[SLOT_W-1:0];
                        r_cnt   <= cnt_eff;
                        r_pos   <= '0;
                        r_crc   <= '0;
                    end
                end
                ST_SEND: begin
                    if (advance) begin
                        r_pos <= n_pos;
                        if (r_pos < tfs_pkg::POS_CRC_HI) begin
                            r_crc <= tfs_pkg::crc_step(r_crc, cur_byte);
                        end
                        if (r_pos == tfs_pkg::POS_CRC_LO) begin
                            r_state <= ST_IDLE;
                            r_ptr   <= (cur_inc >= r_cnt) ? '0 : cur_inc[SLOT_W-1:0];
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (advance) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= cur_byte;
                r_out_last  <= (r_pos == tfs_pkg::POS_CRC_LO);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_byte   = r_out_byte;
    assign o_last      = r_out_last;

endmodule
`default_nettype wire

// ===== rtl/core/telemetry_frame_sender_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// telemetry_frame_sender_unit
// Telemetry payload store with a header-triggered CRC-16 frame sender.
// ---------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): op 0 beats write one payload byte
// of a slot, op 1 beats report the first byte of a received frame. Every
// second header match, counted by a mute flag that starts muted, queues the
// send of one 21-byte frame for the current round-robin slot.
// Output channel (o_out_valid / i_out_stall): one frame byte per beat, with
// o_last on the closing CRC low byte.
// Commands pass through a two-entry queue; the frame engine takes one
// command at a time, applies a payload write as it takes it, and takes no
// new command while a frame is leaving. A frame leaves at one byte per
// cycle while the output is not stalled. The input stalls only while the
// queue is full.
// A stall on the output holds the current byte and freezes the frame engine.
// Reset empties the queue, marks the whole payload store as zero, sets the
// header to 165, the active slot count to 0, the slot pointer to the first
// slot and mutes the sender. Configuration writes take effect at once.
// ---------------------------------------------------------------------------
module telemetry_frame_sender_unit #(
    parameter int unsigned SLOT_COUNT = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tfs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tfs_pkg::BYTE_W-1:0]        i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_op,
    input  wire logic [tfs_pkg::IN_SLOT_W-1:0]     i_slot,
    input  wire logic [tfs_pkg::IDX_W-1:0]         i_byte_index,
    input  wire logic [tfs_pkg::BYTE_W-1:0]        i_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [tfs_pkg::BYTE_W-1:0]             o_tx_byte,
    output logic                                   o_last
);

    logic [tfs_pkg::BYTE_W-1:0] r_header;
    logic [tfs_pkg::ACT_W-1:0]  r_active;

    logic            push;
    logic            pop;
    tfs_pkg::t_cmd   cmd;
    tfs_pkg::t_cmd   head;
    tfs_pkg::t_qstat qstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= tfs_pkg::HEADER_RST;
            r_active <= tfs_pkg::ACTIVE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tfs_pkg::REG_HEADER: r_header <= i_cfg_data;
                tfs_pkg::REG_ACTIVE: r_active <= i_cfg_data[tfs_pkg::ACT_W-1:0];
                default:             r_header <= r_header;
            endcase
        end
    end

    tfs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_slot       (i_slot),
        .i_byte_index (i_byte_index),
        .i_data       (i_data),
        .i_header     (r_header),
        .i_qstat      (qstat),
        .o_push       (push),
        .o_cmd        (cmd)
    );

    tfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    tfs_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .i_header    (r_header),
        .i_active    (r_active),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire
